[design/assert_macros.svh]
// Assertion macros used by the checker file of the hit test block.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SHTU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an implication holds in the same cycle.
`define SHTU_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

[design/shtu_pkg.sv]
// Package of the surface hit test unit: field widths, defaults and the request bus type.
// Used by shtu_cell and surface_hit_test_unit; depends on nothing.
`default_nettype none

package shtu_pkg;

	localparam int MAX_CLIENTS_DEFAULT = 8;
	localparam int SPC_DEFAULT         = 16;

	localparam int CFG_W    = 4;
	localparam int SLOT_W   = 7;
	localparam int CLIENT_W = 3;
	localparam int POS_W    = 16;
	localparam int SIZE_W   = 15;
	localparam int DEPTH_W  = 32;
	localparam int IDENT_W  = 32;

	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 48;

	localparam logic [CFG_W-1:0] CLIENT_COUNT_RESET = 4'd8;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} shtu_op_t;

	// One request as it moves down the cell row, with the running best of a query.
	typedef struct packed {
		logic                      valid;
		shtu_op_t                  op;
		logic [SLOT_W-1:0]         slot;
		logic                      entry_valid;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic [SIZE_W-1:0]         width;
		logic [SIZE_W-1:0]         height;
		logic [DEPTH_W-1:0]        depth_order;
		logic [IDENT_W-1:0]        surface_id;
		logic                      found;
		logic [DEPTH_W-1:0]        best_depth;
		logic [CLIENT_W-1:0]       best_client;
		logic [SLOT_W-1:0]         best_slot;
		logic [IDENT_W-1:0]        best_ident;
	} shtu_bus_t;

endpackage

`default_nettype wire

[design/shtu_cell.sv]
// One table slot of the hit test row: holds the slot's rectangle and updates a passing query.
// Depends on shtu_pkg for the request bus type and field widths.
`default_nettype none

module shtu_cell #(
	parameter int CELL_INDEX          = 0,
	parameter int SURFACES_PER_CLIENT = shtu_pkg::SPC_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [shtu_pkg::CFG_W-1:0]  client_count,
	input  wire shtu_pkg::shtu_bus_t         bus_in,
	output shtu_pkg::shtu_bus_t              bus_out
);
	import shtu_pkg::*;

	localparam int                  CLIENT      = CELL_INDEX / SURFACES_PER_CLIENT;
	localparam bit                  IN_RANGE    = CELL_INDEX < (1 << SLOT_W);
	localparam logic [SLOT_W-1:0]   SLOT_CODE   = SLOT_W'(CELL_INDEX);
	localparam logic [CLIENT_W-1:0] CLIENT_CODE = CLIENT_W'(CLIENT);

	logic                      valid_q;
	logic signed [POS_W-1:0]   left_q;
	logic signed [POS_W-1:0]   top_q;
	logic [SIZE_W-1:0]         width_q;
	logic [SIZE_W-1:0]         height_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic [IDENT_W-1:0]        ident_q;
	shtu_bus_t                 bus_q;

	logic signed [POS_W:0] px, py, lx, ty, rx, by;
	logic                  active;
	logic                  covers;
	logic                  take;
	logic                  write_here;
	shtu_bus_t             bus_next;

	assign active     = int'(client_count) > CLIENT;
	assign write_here = IN_RANGE && bus_in.valid && (bus_in.op == OP_WRITE)
		&& (bus_in.slot == SLOT_CODE);

	always_comb begin
		px = {bus_in.pos_x[POS_W-1], bus_in.pos_x};
		py = {bus_in.pos_y[POS_W-1], bus_in.pos_y};
		lx = {left_q[POS_W-1], left_q};
		ty = {top_q[POS_W-1], top_q};
		rx = lx + signed'({2'b00, width_q});
		by = ty + signed'({2'b00, height_q});
		covers = valid_q && (width_q != '0) && (height_q != '0)
			&& (px >= lx) && (py >= ty) && (px < rx) && (py < by);
		// later slot wins on equal depth
		take = bus_in.valid && (bus_in.op == OP_QUERY) && active && covers
			&& (!bus_in.found || (depth_q >= bus_in.best_depth));
	end

	always_comb begin
		bus_next = bus_in;
		if (take) begin
			bus_next.found       = 1'b1;
			bus_next.best_depth  = depth_q;
			bus_next.best_client = CLIENT_CODE;
			bus_next.best_slot   = SLOT_CODE;
			bus_next.best_ident  = ident_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			bus_q   <= '0;
		end else if (advance) begin
			bus_q <= bus_next;
			if (write_here) begin
				valid_q <= bus_in.entry_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && write_here) begin
			left_q   <= bus_in.pos_x;
			top_q    <= bus_in.pos_y;
			width_q  <= bus_in.width;
			height_q <= bus_in.height;
			depth_q  <= bus_in.depth_order;
			ident_q  <= bus_in.surface_id;
		end
	end

	assign bus_out = bus_q;

endmodule

`default_nettype wire

[design/surface_hit_test_unit.sv]
// Throughput: one request per cycle while the row is not stalled.
// Each slot cell is one register stage of the row, and an output register follows the last cell.
// A result held at the output stalls the row only when the next finished query reaches its end.
// Writes travel the same row, so every query sees exactly the writes accepted before it.
// Reset clears all slot valid bits and sets client_count to 8; rectangle contents stay undefined.
`default_nettype none

module surface_hit_test_unit #(
	parameter int MAX_CLIENTS         = shtu_pkg::MAX_CLIENTS_DEFAULT,
	parameter int SURFACES_PER_CLIENT = shtu_pkg::SPC_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// slot[6:0], entry_valid[7], pos_x[23:8], pos_y[39:24], width[54:40], height[69:55],
	// depth_order[101:70], surface_id[133:102], zero fill[135:134]
	input  wire logic [shtu_pkg::S_TDATA_W-1:0] s_tdata,
	// opcode[0]
	input  wire logic                           s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// hit_client[2:0], hit_slot[9:3], hit_surface_id[41:10], zero fill[47:42]
	output logic [shtu_pkg::M_TDATA_W-1:0]      m_tdata,
	// hit[0]
	output logic                                m_tuser,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [shtu_pkg::CFG_W-1:0]     cfg_data
);
	import shtu_pkg::*;

	localparam int CELLS = MAX_CLIENTS * SURFACES_PER_CLIENT;

	logic [CFG_W-1:0] client_count_q;
	shtu_bus_t        chain [0:CELLS];
	logic             advance;
	logic             last_query;
	logic             out_valid_q;
	logic             out_hit_q;
	logic [CLIENT_W-1:0] out_client_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [IDENT_W-1:0]  out_ident_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_count_q <= CLIENT_COUNT_RESET;
		end else if (cfg_valid) begin
			client_count_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	always_comb begin
		chain[0]             = '0;
		chain[0].valid       = s_tvalid;
		chain[0].op          = shtu_op_t'(s_tuser);
		chain[0].slot        = s_tdata[6:0];
		chain[0].entry_valid = s_tdata[7];
		chain[0].pos_x       = s_tdata[23:8];
		chain[0].pos_y       = s_tdata[39:24];
		chain[0].width       = s_tdata[54:40];
		chain[0].height      = s_tdata[69:55];
		chain[0].depth_order = s_tdata[101:70];
		chain[0].surface_id  = s_tdata[133:102];
	end

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		shtu_cell #(
			.CELL_INDEX          (k),
			.SURFACES_PER_CLIENT (SURFACES_PER_CLIENT)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (advance),
			.client_count (client_count_q),
			.bus_in       (chain[k]),
			.bus_out      (chain[k+1])
		);
	end

	// writes and bubbles drop off the end of the row
	assign last_query = chain[CELLS].valid && (chain[CELLS].op == OP_QUERY);
	assign advance    = !last_query || !out_valid_q || m_tready;
	assign s_tready   = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_query) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_query) begin
			out_hit_q    <= chain[CELLS].found;
			out_client_q <= chain[CELLS].best_client;
			out_slot_q   <= chain[CELLS].best_slot;
			out_ident_q  <= chain[CELLS].best_ident;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {6'b0, out_ident_q, out_slot_q, out_client_q};

endmodule

`default_nettype wire

[design/shtu_checker.sv]
// Port-level checks of the surface hit test unit, attached to the top level by bind.
// Depends on assert_macros.svh and on the top level's port names.
`default_nettype none
`include "assert_macros.svh"

module shtu_checker #(
	parameter int SURFACES_PER_CLIENT = 16,
	parameter int SLOT_COUNT          = 128
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tuser
);

	// hold a result until it is taken
	`SHTU_ASSERT(a_hold_result, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")

	// a miss reports all zero
	`SHTU_ASSERT_IMPLY(a_miss_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == 48'd0, "miss with nonzero fields")

	// client index follows from the slot when slot numbers are not truncated
	`SHTU_ASSERT_IMPLY(a_client_of_slot, clk, arst_n, m_tvalid && m_tuser && (SLOT_COUNT <= 128), m_tdata[2:0] == 3'(int'(m_tdata[9:3]) / SURFACES_PER_CLIENT), "client does not match slot")

	// with no result pending the row always takes a request
	`SHTU_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready, "request refused with empty output")

endmodule

bind surface_hit_test_unit shtu_checker #(
	.SURFACES_PER_CLIENT (SURFACES_PER_CLIENT),
	.SLOT_COUNT          (MAX_CLIENTS * SURFACES_PER_CLIENT)
) u_shtu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
